@@ hdl/life_like_grid_automaton_assert.svh @@
// Assertion macros for the life-like grid automaton.
`ifndef LIFE_LIKE_GRID_AUTOMATON_ASSERT_SVH
`define LIFE_LIKE_GRID_AUTOMATON_ASSERT_SVH
`ifndef SYNTH
// Checked outside reset.
`define LLGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define LLGA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLGA_ASSERT(lbl, prop, msg)
`define LLGA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hdl/llga_pkg.sv @@
// Shared constants for the life-like grid automaton.
package llga_pkg;

  localparam int DEF_GRID_WIDTH  = 80;
  localparam int DEF_GRID_HEIGHT = 24;

  localparam int KIND_W    = 2;
  localparam int IDX_W     = 11;
  localparam int THR_W     = 4;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

  localparam logic [THR_W-1:0] BIRTH_RST   = 4'd3;
  localparam logic [THR_W-1:0] SURVIVE_RST = 4'd2;

  // Register word index, taken from paddr[2].
  localparam logic REG_BIRTH   = 1'b0;
  localparam logic REG_SURVIVE = 1'b1;

endpackage

@@ hdl/life_like_grid_automaton.sv @@
// Life-like cellular automaton on a one-bit cell grid held in one memory.
//
// Input stream (s_t*): one beat per command. Kind write stores one cell, kind
// read fetches one cell, kind advance steps the whole grid by one generation;
// the unused kind does nothing. Every command returns exactly one beat on the
// output stream (m_t*): the cell value for a read, zero otherwise. Indexes past
// the grid are ignored on write and read back as dead.
// A write or unused command finishes when it is accepted, a read after a
// registered memory read, an advance once the last new cell is written. The
// advance streams every cell through the memory read port once, in raster
// order, into a window of two rows plus three cells and writes each new cell
// back in place behind the read pointer, one cell per cycle.
// Reset: the thresholds return to birth 3 and survive 2, then a clearing pass
// writes every cell dead, one per cycle; no command is taken until it ends.
// The APB port is live throughout.
// Stall: a finished result waits in the output register while the next command
// is accepted; if the receiver still holds it when the next result is ready,
// the block holds that result and takes no command until the register frees.
// APB: birth_min at byte address 0, survive_min at 4 (decoded on paddr[2]).
`include "life_like_grid_automaton_assert.svh"

module life_like_grid_automaton
  import llga_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  // command stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // kind[1:0], cell_index[12:2], cell_value[13]
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // cell_alive[0]
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int CELLS   = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW      = $clog2(CELLS);
  localparam int SW      = $clog2(CELLS + GRID_WIDTH + 2);
  localparam int RW      = $clog2(GRID_HEIGHT);
  localparam int CW      = $clog2(GRID_WIDTH);
  // window: newest cell at bit 0, center at GRID_WIDTH+1
  localparam int WIN_LEN = 2 * GRID_WIDTH + 3;
  localparam int LAST_RD = CELLS + GRID_WIDTH;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_ADV  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;

  logic [2:0]         state, state_next;
  logic [THR_W-1:0]   birth_min, survive_min;

  logic [KIND_W-1:0]  in_kind;
  logic [IDX_W-1:0]   in_index;
  logic               in_value;
  logic               acc, idx_ok;
  logic [AW-1:0]      idx_addr;

  // cell memory
  logic               mem [CELLS];
  logic               mem_we, mem_wd, mem_q;
  logic [AW-1:0]      mem_wa, mem_ra;

  logic [AW-1:0]      clr_addr;
  logic               rd_ok;

  // advance sweep
  logic [SW-1:0]      rd_cnt, sh_cnt;
  logic               issue, b_valid, c_on;
  logic [WIN_LEN-1:0] win;
  logic [AW-1:0]      wr_addr;
  logic [RW-1:0]      ctr_row;
  logic [CW-1:0]      ctr_col;
  logic               has_up, has_dn, has_lf, has_rt;
  logic [THR_W-1:0]   live_cnt;
  logic               alive, last_cell;

  // result path
  logic               fin, fin_bit, slot_free, out_bit, pend_bit;

  assign in_kind  = s_tdata[KIND_W-1:0];
  assign in_index = s_tdata[KIND_W+IDX_W-1:KIND_W];
  assign in_value = s_tdata[KIND_W+IDX_W];
  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign idx_ok   = (32'(in_index) < 32'(CELLS));
  assign idx_addr = AW'(in_index);

  assign m_tdata   = {{(M_TDATA_W-1){1'b0}}, out_bit};
  assign slot_free = !m_tvalid || m_tready;

  // APB: no wait states, partial decode on the word bit
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_BIRTH:   prdata = PDATA_W'(birth_min);
      REG_SURVIVE: prdata = PDATA_W'(survive_min);
      default:     prdata = '0;
    endcase
  end

  // neighborhood of the center cell, masked at the grid edges
  assign has_up = (ctr_row != RW'(0));
  assign has_dn = (ctr_row != RW'(GRID_HEIGHT - 1));
  assign has_lf = (ctr_col != CW'(0));
  assign has_rt = (ctr_col != CW'(GRID_WIDTH - 1));

  assign live_cnt = THR_W'(win[2*GRID_WIDTH+2] & has_up & has_lf)
                  + THR_W'(win[2*GRID_WIDTH+1] & has_up)
                  + THR_W'(win[2*GRID_WIDTH]   & has_up & has_rt)
                  + THR_W'(win[GRID_WIDTH+2]   & has_lf)
                  + THR_W'(win[GRID_WIDTH]     & has_rt)
                  + THR_W'(win[2]              & has_dn & has_lf)
                  + THR_W'(win[1]              & has_dn)
                  + THR_W'(win[0]              & has_dn & has_rt);

  assign alive = (win[GRID_WIDTH+1] && (live_cnt >= survive_min))
              || (live_cnt >= birth_min);
  assign last_cell = (wr_addr == AW'(CELLS - 1));
  assign issue     = (state == ST_ADV) && (rd_cnt <= SW'(LAST_RD));

  // control
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_bit    = 1'b0;
    unique case (state)
      ST_CLR: begin
        if (clr_addr == AW'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (in_kind)
            KIND_READ: state_next = ST_READ;
            KIND_STEP: state_next = ST_ADV;
            default:   fin = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        fin     = 1'b1;
        fin_bit = rd_ok & mem_q;
      end
      ST_ADV: begin
        fin = c_on && last_cell;
      end
      ST_POST: begin
        fin     = 1'b1;
        fin_bit = pend_bit;
      end
      default: state_next = ST_IDLE;
    endcase
    if (fin) state_next = slot_free ? ST_IDLE : ST_POST;
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_addr;
    mem_wd = in_value;
    if (state == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = 1'b0;
    end else if (state == ST_ADV) begin
      mem_we = c_on;
      mem_wa = wr_addr;
      mem_wd = alive;
    end else begin
      mem_we = acc && (in_kind == KIND_WRITE) && idx_ok;
    end
    mem_ra = (state == ST_ADV) ? rd_cnt[AW-1:0] : idx_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      clr_addr    <= '0;
      birth_min   <= BIRTH_RST;
      survive_min <= SURVIVE_RST;
      m_tvalid    <= 1'b0;
      b_valid     <= 1'b0;
      c_on        <= 1'b0;
      rd_cnt      <= '0;
      sh_cnt      <= '0;
      wr_addr     <= '0;
      ctr_row     <= '0;
      ctr_col     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) clr_addr <= clr_addr + AW'(1);

      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          REG_BIRTH:   birth_min   <= pwdata[THR_W-1:0];
          REG_SURVIVE: survive_min <= pwdata[THR_W-1:0];
          default: ;
        endcase
      end

      // start a sweep
      if (acc && (in_kind == KIND_STEP)) begin
        rd_cnt  <= '0;
        sh_cnt  <= '0;
        wr_addr <= '0;
        ctr_row <= '0;
        ctr_col <= '0;
      end else begin
        if (issue) rd_cnt <= rd_cnt + SW'(1);
        if (b_valid) sh_cnt <= sh_cnt + SW'(1);
        if (c_on) begin
          wr_addr <= wr_addr + AW'(1);
          if (ctr_col == CW'(GRID_WIDTH - 1)) begin
            ctr_col <= '0;
            ctr_row <= ctr_row + RW'(1);
          end else begin
            ctr_col <= ctr_col + CW'(1);
          end
        end
      end
      b_valid <= issue;
      // center is valid once the window holds a full row and two cells past it
      c_on    <= b_valid && (sh_cnt >= SW'(GRID_WIDTH + 1));

      if (fin && slot_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) rd_ok <= idx_ok;
    if (b_valid) win <= {win[WIN_LEN-2:0], mem_q};
    if (fin && slot_free) out_bit <= fin_bit;
    if (fin && !slot_free) pend_bit <= fin_bit;
  end

  // write-back trails the read pointer, never the same cell in one cycle
  `LLGA_ASSERT(a_no_rw_clash, c_on && issue |-> wr_addr != rd_cnt[AW-1:0], "sweep write hits read cell")
  `LLGA_ASSERT(a_center_in_adv, c_on |-> state == ST_ADV, "window center outside an advance")
  `LLGA_ASSERT(a_sweep_drained, state == ST_ADV && fin |-> !b_valid && !issue, "advance ends with sweep in flight")
  `LLGA_ASSERT_RST(a_reset_clears, rst |=> state == ST_CLR && !m_tvalid && !c_on, "reset does not start clearing")

endmodule
